@@ rtl/core/apt_pkg.sv @@
`default_nettype none

package apt_pkg;

    // Command codes on the request channel
    typedef enum logic [1:0] {
        CMD_INIT  = 2'd0,
        CMD_ADD   = 2'd1,
        CMD_CHECK = 2'd2
    } cmd_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_SUCCESS      = 2'd0,
        ST_DENIED       = 2'd1,
        ST_DEFAULT_DENY = 2'd2,
        ST_FULL         = 2'd3
    } status_t;

    // Operation carried by a request as it travels along the chain
    typedef enum logic [1:0] {
        OP_NONE  = 2'd0,
        OP_ADD   = 2'd1,
        OP_CHECK = 2'd2
    } op_t;

    // Mask that allows every action
    localparam logic [2:0] ALL_ACTIONS = 3'd7;

    // Request token handed from cell to cell
    typedef struct packed {
        op_t         op;
        logic [31:0] subject_id;
        logic [31:0] object_id;
        logic [2:0]  action_mask;
        logic        done;
        status_t     status;
    } token_t;

endpackage

`default_nettype wire

@@ rtl/core/apt_cell.sv @@
`default_nettype none

module apt_cell #(
    parameter int CNT_W = 8
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              adv,
    input  wire logic              tok_valid_in,
    input  wire apt_pkg::token_t   tok_in,
    input  wire logic [CNT_W-1:0]  left_in,
    output logic                   tok_valid_out,
    output apt_pkg::token_t        tok_out,
    output logic [CNT_W-1:0]       left_out
);

    // One policy entry, written by each add request that lands here
    logic [31:0] subject_reg;
    logic [31:0] object_reg;
    logic [2:0]  mask_reg;

    logic            valid_reg;
    apt_pkg::token_t tok_reg;
    apt_pkg::token_t tok_next;
    logic [CNT_W-1:0] left_reg;
    logic [CNT_W-1:0] left_next;
    logic            wr_en;

    // A request counts down the live entries it has still to pass. When the count is
    // zero this cell is the first free slot; otherwise it holds a written entry.
    always_comb
    begin
        tok_next  = tok_in;
        left_next = left_in;
        wr_en     = 1'b0;
        if (tok_valid_in && !tok_in.done)
        begin
            if (left_in == '0)
            begin
                if (tok_in.op == apt_pkg::OP_ADD)
                begin
                    wr_en           = 1'b1;
                    tok_next.done   = 1'b1;
                    tok_next.status = apt_pkg::ST_SUCCESS;
                end
                else if (tok_in.op == apt_pkg::OP_CHECK)
                begin
                    tok_next.done   = 1'b1;
                    tok_next.status = apt_pkg::ST_DEFAULT_DENY;
                end
            end
            else
            begin
                left_next = left_in - 1'b1;
                if (tok_in.op == apt_pkg::OP_CHECK &&
                    subject_reg == tok_in.subject_id &&
                    object_reg == tok_in.object_id)
                begin
                    tok_next.done = 1'b1;
                    if ((mask_reg & tok_in.action_mask) == tok_in.action_mask)
                    begin
                        tok_next.status = apt_pkg::ST_SUCCESS;
                    end
                    else
                    begin
                        tok_next.status = apt_pkg::ST_DENIED;
                    end
                end
            end
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (adv && wr_en)
        begin
            subject_reg <= tok_in.subject_id;
            object_reg  <= tok_in.object_id;
            mask_reg    <= tok_in.action_mask;
        end
    end

    // Token payload stage
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tok_reg  <= tok_next;
            left_reg <= left_next;
        end
    end

    // Token valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= tok_valid_in;
        end
    end

    assign tok_valid_out = valid_reg;
    assign tok_out       = tok_reg;
    assign left_out      = left_reg;

endmodule

`default_nettype wire

@@ rtl/core/access_policy_table.sv @@
// First-match access-control table built as a chain of TABLE_DEPTH cells, one policy
// entry per cell. Every request (init, add or check) enters the head of the chain and
// moves one cell per cycle: an add writes its entry into the first free cell, a check
// is decided by the first written cell whose subject and object match. A new request
// is taken every cycle while the chain is not stalled, and its result passes through
// the chain of TABLE_DEPTH cell registers and then the output register.
// Results leave in request order. A stall on the result side freezes the whole chain,
// and the request side stalls with it.
`default_nettype none

module access_policy_table #(
    parameter int TABLE_DEPTH = 128
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  command,
    input  wire logic [31:0] subject_id,
    input  wire logic [31:0] object_id,
    input  wire logic [2:0]  action_mask,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             ok,
    output logic [1:0]       status
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             adv;
    logic             in_acc;
    logic             out_valid_reg;
    logic             ok_reg;
    apt_pkg::status_t status_reg;
    apt_pkg::status_t end_status;

    logic             chain_valid [0:TABLE_DEPTH];
    apt_pkg::token_t  chain_tok   [0:TABLE_DEPTH];
    logic [CNT_W-1:0] chain_left  [0:TABLE_DEPTH];

    // The chain moves whenever the output register is free or being emptied
    assign adv      = !out_valid_reg || !out_stall;
    assign in_stall = !adv;
    assign in_acc   = in_valid && adv;

    // Build the head token and the new entry count from the request
    always_comb
    begin
        chain_valid[0]             = in_acc;
        chain_tok[0].op            = apt_pkg::OP_NONE;
        chain_tok[0].subject_id    = subject_id;
        chain_tok[0].object_id     = object_id;
        chain_tok[0].action_mask   = action_mask;
        chain_tok[0].done          = 1'b0;
        chain_tok[0].status        = apt_pkg::ST_DEFAULT_DENY;
        chain_left[0]              = count_reg;
        count_next                 = count_reg;
        case (apt_pkg::cmd_t'(command))
            apt_pkg::CMD_INIT:
            begin
                // Init empties the table and adds the default entry at the first slot
                chain_tok[0].op          = apt_pkg::OP_ADD;
                chain_tok[0].subject_id  = '0;
                chain_tok[0].object_id   = '0;
                chain_tok[0].action_mask = apt_pkg::ALL_ACTIONS;
                chain_left[0]            = '0;
                count_next               = CNT_W'(1);
            end
            apt_pkg::CMD_ADD:
            begin
                chain_tok[0].op = apt_pkg::OP_ADD;
                if (count_reg != CNT_W'(TABLE_DEPTH))
                begin
                    count_next = count_reg + 1'b1;
                end
            end
            apt_pkg::CMD_CHECK:
            begin
                chain_tok[0].op = apt_pkg::OP_CHECK;
            end
            default:
            begin
                chain_tok[0].op = apt_pkg::OP_NONE;
            end
        endcase
    end

    // Entry count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (in_acc)
        begin
            count_reg <= count_next;
        end
    end

    // Row of entry cells
    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        apt_cell #(
            .CNT_W (CNT_W)
        ) u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .adv           (adv),
            .tok_valid_in  (chain_valid[i]),
            .tok_in        (chain_tok[i]),
            .left_in       (chain_left[i]),
            .tok_valid_out (chain_valid[i+1]),
            .tok_out       (chain_tok[i+1]),
            .left_out      (chain_left[i+1])
        );
    end

    // A request that leaves the chain undecided found no free slot or no matching entry
    always_comb
    begin
        if (chain_tok[TABLE_DEPTH].done)
        begin
            end_status = chain_tok[TABLE_DEPTH].status;
        end
        else if (chain_tok[TABLE_DEPTH].op == apt_pkg::OP_ADD)
        begin
            end_status = apt_pkg::ST_FULL;
        end
        else
        begin
            end_status = apt_pkg::ST_DEFAULT_DENY;
        end
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ok_reg     <= (end_status == apt_pkg::ST_SUCCESS);
            status_reg <= end_status;
        end
    end

    // Output register valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= chain_valid[TABLE_DEPTH];
        end
    end

    assign out_valid = out_valid_reg;
    assign ok        = ok_reg;
    assign status    = status_reg;

    // The entry count never exceeds the table depth
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    // An accepted init leaves exactly one entry
    a_init_count: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && command == apt_pkg::CMD_INIT |=> count_reg == CNT_W'(1))
        else $error("init did not leave one entry");

    // The ok flag agrees with the status of the result
    a_ok_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ok_reg == (status_reg == apt_pkg::ST_SUCCESS))
        else $error("ok flag disagrees with status");

    // Requests are held back only while a result waits under stall
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid_reg && out_stall)
        else $error("request stalled without result backpressure");

    // An add on a full table keeps the count
    a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && command == apt_pkg::CMD_ADD && count_reg == CNT_W'(TABLE_DEPTH)
        |=> count_reg == CNT_W'(TABLE_DEPTH))
        else $error("add on full table changed the count");

endmodule

`default_nettype wire

@@ tb/sv/access_policy_table_tb.sv @@
`default_nettype none

module access_policy_table_tb;

    import apt_pkg::*;

    localparam int TABLE_DEPTH    = 128;
    localparam int RANDOM_ITEMS   = 1330;
    localparam int QUIET_TAIL     = 150;
    localparam int HOLDOFF_CYCLES = 400;
    localparam int STALL_LIMIT    = 5000;

    // The one command code that the package leaves without a name
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // One answer of the table as the result channel carries it
    typedef struct packed {
        logic    ok;
        status_t status;
    } verdict_t;

    // One row of the directed table; typed rows carry their answer
    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] subject_id;
        logic [31:0] object_id;
        logic [2:0]  action_mask;
        logic        typed;
        logic        ok;
        status_t     status;
    } request_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  command;
    logic [31:0] subject_id;
    logic [31:0] object_id;
    logic [2:0]  action_mask;
    logic        out_valid;
    logic        out_stall;
    logic        ok;
    logic [1:0]  status;

    // Shadow copy of the policy table
    logic [31:0] table_subject [TABLE_DEPTH];
    logic [31:0] table_object [TABLE_DEPTH];
    logic [2:0]  table_mask [TABLE_DEPTH];
    int          table_entries;

    verdict_t    expected_verdicts [$];
    verdict_t    oldest_verdict;
    int          mismatch_count;
    int          sent_count;
    int          received_count;
    int          stuck_cycles;
    int          send_gap_odds;
    bit          quiet;
    bit          holdoff_done;
    int          calm_left;

    request_row_t directed_rows [0:22];

    access_policy_table #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .command     (command),
        .subject_id  (subject_id),
        .object_id   (object_id),
        .action_mask (action_mask),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .ok          (ok),
        .status      (status)
    );

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    // Appends one entry to the shadow table; false when it is already full.
    function automatic bit append_policy(logic [31:0] subj, logic [31:0] obj, logic [2:0] mask);
        if (table_entries >= TABLE_DEPTH)
            return 1'b0;
        table_subject[table_entries] = subj;
        table_object[table_entries]  = obj;
        table_mask[table_entries]    = mask;
        table_entries++;
        return 1'b1;
    endfunction

    // Applies one request to the shadow table and works out its answer.
    function automatic verdict_t evaluate_request(logic [1:0] cmd, logic [31:0] subj,
                                                  logic [31:0] obj, logic [2:0] mask);
        verdict_t v;
        bit       found;
        v.ok     = 1'b0;
        v.status = ST_DEFAULT_DENY;
        found    = 1'b0;
        case (cmd)
            CMD_INIT:
            begin
                table_entries = 0;
                if (append_policy(32'd0, 32'd0, ALL_ACTIONS))
                begin
                    v.ok     = 1'b1;
                    v.status = ST_SUCCESS;
                end
                else
                    v.status = ST_FULL;
            end
            CMD_ADD:
            begin
                if (append_policy(subj, obj, mask))
                begin
                    v.ok     = 1'b1;
                    v.status = ST_SUCCESS;
                end
                else
                    v.status = ST_FULL;
            end
            CMD_CHECK:
            begin
                // The first matching entry in insertion order decides.
                for (int i = 0; i < table_entries; i++)
                begin
                    if (!found && table_subject[i] == subj && table_object[i] == obj)
                    begin
                        found    = 1'b1;
                        v.status = ((table_mask[i] & mask) == mask) ? ST_SUCCESS : ST_DENIED;
                    end
                end
                v.ok = (v.status == ST_SUCCESS);
            end
            default:
            begin
                // The unused code is refused and leaves the table alone.
                v.ok     = 1'b0;
                v.status = ST_DEFAULT_DENY;
            end
        endcase
        return v;
    endfunction

    // Offers one request, holds it until accepted and records its answer.
    task automatic send_request(input logic [1:0] cmd, input logic [31:0] subj,
                                input logic [31:0] obj, input logic [2:0] mask,
                                input logic typed, input logic exp_ok,
                                input status_t exp_status);
        verdict_t v;
        if (!quiet && send_gap_odds != 0 && $urandom_range(1, send_gap_odds) == 1)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clk);
        end
        in_valid    = 1'b1;
        command     = cmd;
        subject_id  = subj;
        object_id   = obj;
        action_mask = mask;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        v = evaluate_request(cmd, subj, obj, mask);
        if (typed)
        begin
            v.ok     = exp_ok;
            v.status = exp_status;
        end
        expected_verdicts.push_back(v);
        sent_count++;
        if (sent_count > 25 + RANDOM_ITEMS - QUIET_TAIL)
            quiet = 1'b1;
        @(negedge clk);
    endtask

    // Picks an identifier, often from a small range so that pairs collide.
    function automatic logic [31:0] pick_id();
        if ($urandom_range(0, 2) == 0)
            return $urandom;
        return $urandom_range(0, 7);
    endfunction

    // Check fields: mostly a stored pair, sometimes one bit off, sometimes arbitrary.
    task automatic pick_check_request(output logic [31:0] subj, output logic [31:0] obj,
                                      output logic [2:0] mask);
        int idx;
        int r;
        r    = $urandom_range(0, 99);
        mask = 3'($urandom_range(0, 7));
        if (table_entries > 0 && r < 65)
        begin
            idx  = $urandom_range(0, table_entries - 1);
            subj = table_subject[idx];
            obj  = table_object[idx];
            if ($urandom_range(0, 4) == 0)
            begin
                if ($urandom_range(0, 1) == 0)
                    subj = subj ^ (32'd1 << $urandom_range(0, 31));
                else
                    obj = obj ^ (32'd1 << $urandom_range(0, 31));
            end
        end
        else
        begin
            subj = pick_id();
            obj  = pick_id();
        end
    endtask

    // New entry fields: sometimes a pair already stored, to exercise first-match.
    task automatic pick_new_entry(output logic [31:0] subj, output logic [31:0] obj,
                                  output logic [2:0] mask);
        int idx;
        mask = 3'($urandom_range(0, 7));
        if (table_entries > 0 && $urandom_range(0, 3) == 0)
        begin
            idx  = $urandom_range(0, table_entries - 1);
            subj = table_subject[idx];
            obj  = table_object[idx];
        end
        else
        begin
            subj = pick_id();
            obj  = pick_id();
        end
    endtask

    // Result checker: every accepted result against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_verdicts.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual ok %0b status %0d",
                         $time, ok, status);
                mismatch_count++;
            end
            else
            begin
                oldest_verdict = expected_verdicts.pop_front();
                if (ok !== oldest_verdict.ok)
                begin
                    $display("%0t: ok mismatch, expected %0b, actual %0b",
                             $time, oldest_verdict.ok, ok);
                    mismatch_count++;
                end
                if (status !== oldest_verdict.status)
                begin
                    $display("%0t: status mismatch, expected %0d, actual %0d",
                             $time, oldest_verdict.status, status);
                    mismatch_count++;
                end
            end
            received_count++;
        end
    end

    // Counts cycles in which neither channel moves anything
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    initial
    begin
        wait (stuck_cycles >= STALL_LIMIT);
        $display("access_policy_table verification failed");
        $finish;
    end

    // Result side: short stall bursts, calm stretches and one long hold-off
    initial
    begin
        out_stall    = 1'b0;
        holdoff_done = 1'b0;
        calm_left    = 0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (!holdoff_done && received_count >= 300)
            begin
                // Long hold-off so that the chain fills and the request side stalls.
                holdoff_done = 1'b1;
                out_stall    = 1'b1;
                repeat (HOLDOFF_CYCLES) @(negedge clk);
                out_stall = 1'b0;
            end
            else if (calm_left > 0)
                calm_left--;
            else if ($urandom_range(0, 99) == 0)
                calm_left = $urandom_range(50, 200);
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                out_stall = 1'b1;
                repeat ($urandom_range(1, 7)) @(negedge clk);
                out_stall = 1'b0;
            end
        end
    end

    // Request side: reset, directed table, then random phases
    initial
    begin
        logic [31:0] subj;
        logic [31:0] obj;
        logic [2:0]  mask;
        int          phase;
        int          length;
        int          r;
        bit          late_fill_done;

        rst_n          = 1'b0;
        in_valid       = 1'b0;
        command        = CMD_INIT;
        subject_id     = 32'd0;
        object_id      = 32'd0;
        action_mask    = 3'd0;
        table_entries  = 0;
        mismatch_count = 0;
        sent_count     = 0;
        received_count = 0;
        send_gap_odds  = 4;
        quiet          = 1'b0;
        late_fill_done = 1'b0;
        phase          = 0;

        directed_rows = '{
            // Empty table after reset: default deny.
            '{CMD_CHECK,  32'h0000_0000, 32'h0000_0000, 3'd7, 1'b1, 1'b0, ST_DEFAULT_DENY},
            '{CMD_ADD,    32'h0000_0005, 32'h0000_0006, 3'd3, 1'b1, 1'b1, ST_SUCCESS},
            '{CMD_CHECK,  32'h0000_0005, 32'h0000_0006, 3'd1, 1'b0, 1'b0, ST_SUCCESS},
            '{CMD_INIT,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd0, 1'b1, 1'b1, ST_SUCCESS},
            '{CMD_CHECK,  32'h0000_0005, 32'h0000_0006, 3'd1, 1'b0, 1'b0, ST_SUCCESS},
            // The default entry allows everything, and an empty request too.
            '{CMD_CHECK,  32'h0000_0000, 32'h0000_0000, 3'd7, 1'b1, 1'b1, ST_SUCCESS},
            '{CMD_CHECK,  32'h0000_0000, 32'h0000_0000, 3'd0, 1'b1, 1'b1, ST_SUCCESS},
            '{CMD_ADD,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd0, 1'b1, 1'b1, ST_SUCCESS},
            '{CMD_CHECK,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd0, 1'b0, 1'b0, ST_SUCCESS},
            '{CMD_CHECK,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd1, 1'b0, 1'b0, ST_SUCCESS},
            // A later duplicate is shadowed by the earlier entry.
            '{CMD_ADD,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd7, 1'b1, 1'b1, ST_SUCCESS},
            '{CMD_CHECK,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd7, 1'b0, 1'b0, ST_SUCCESS},
            '{CMD_CHECK,  32'hFFFF_FFFF, 32'hFFFF_FFFE, 3'd0, 1'b0, 1'b0, ST_SUCCESS},
            '{CMD_ADD,    32'h0000_0000, 32'hFFFF_FFFF, 3'd5, 1'b1, 1'b1, ST_SUCCESS},
            '{CMD_CHECK,  32'h0000_0000, 32'hFFFF_FFFF, 3'd4, 1'b0, 1'b0, ST_SUCCESS},
            '{CMD_CHECK,  32'h0000_0000, 32'hFFFF_FFFF, 3'd6, 1'b0, 1'b0, ST_SUCCESS},
            '{CMD_CHECK,  32'hFFFF_FFFF, 32'h0000_0000, 3'd1, 1'b0, 1'b0, ST_SUCCESS},
            // The unused code is refused.
            '{CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd7, 1'b1, 1'b0, ST_DEFAULT_DENY},
            '{CMD_CHECK,  32'h0000_0000, 32'hFFFF_FFFF, 3'd1, 1'b0, 1'b0, ST_SUCCESS},
            '{CMD_ADD,    32'h8000_0000, 32'h0000_0001, 3'd2, 1'b1, 1'b1, ST_SUCCESS},
            '{CMD_CHECK,  32'h8000_0000, 32'h0000_0001, 3'd2, 1'b0, 1'b0, ST_SUCCESS},
            '{CMD_INIT,   32'h0000_0000, 32'h0000_0000, 3'd7, 1'b1, 1'b1, ST_SUCCESS},
            '{CMD_CHECK,  32'h0000_0000, 32'hFFFF_FFFF, 3'd1, 1'b0, 1'b0, ST_SUCCESS}
        };

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
            send_request(directed_rows[i].command, directed_rows[i].subject_id,
                         directed_rows[i].object_id, directed_rows[i].action_mask,
                         directed_rows[i].typed, directed_rows[i].ok,
                         directed_rows[i].status);

        while (sent_count < 25 + RANDOM_ITEMS)
        begin
            phase++;
            r = $urandom_range(0, 2);
            send_gap_odds = (r == 0) ? 0 : ((r == 1) ? 3 : 10);
            if (phase == 1 || (!late_fill_done && sent_count > 800))
            begin
                // Fill the table to the top and keep adding past it.
                if (phase != 1)
                    late_fill_done = 1'b1;
                send_request(CMD_INIT, $urandom, $urandom, 3'($urandom_range(0, 7)),
                             1'b0, 1'b0, ST_SUCCESS);
                repeat (TABLE_DEPTH + 6)
                begin
                    if ($urandom_range(0, 3) == 0)
                    begin
                        pick_check_request(subj, obj, mask);
                        send_request(CMD_CHECK, subj, obj, mask, 1'b0, 1'b0, ST_SUCCESS);
                    end
                    pick_new_entry(subj, obj, mask);
                    send_request(CMD_ADD, subj, obj, mask, 1'b0, 1'b0, ST_SUCCESS);
                end
                repeat (20)
                begin
                    pick_check_request(subj, obj, mask);
                    send_request(CMD_CHECK, subj, obj, mask, 1'b0, 1'b0, ST_SUCCESS);
                end
            end
            else if ($urandom_range(0, 9) == 0)
            begin
                // Noise: any command with arbitrary fields.
                repeat ($urandom_range(10, 30))
                    send_request(2'($urandom_range(0, 3)), $urandom, $urandom,
                                 3'($urandom_range(0, 7)), 1'b0, 1'b0, ST_SUCCESS);
            end
            else
            begin
                // A session of adds and checks, usually from a fresh table.
                if ($urandom_range(0, 9) < 7)
                    send_request(CMD_INIT, $urandom, $urandom, 3'($urandom_range(0, 7)),
                                 1'b0, 1'b0, ST_SUCCESS);
                length = $urandom_range(5, 60);
                repeat (length)
                begin
                    r = $urandom_range(0, 99);
                    if (r < 40)
                    begin
                        pick_new_entry(subj, obj, mask);
                        send_request(CMD_ADD, subj, obj, mask, 1'b0, 1'b0, ST_SUCCESS);
                    end
                    else if (r < 95)
                    begin
                        pick_check_request(subj, obj, mask);
                        send_request(CMD_CHECK, subj, obj, mask, 1'b0, 1'b0, ST_SUCCESS);
                    end
                    else if (r < 98)
                        send_request(CMD_UNUSED, $urandom, $urandom,
                                     3'($urandom_range(0, 7)), 1'b0, 1'b0, ST_SUCCESS);
                    else
                        send_request(CMD_INIT, $urandom, $urandom,
                                     3'($urandom_range(0, 7)), 1'b0, 1'b0, ST_SUCCESS);
                end
            end
        end

        in_valid = 1'b0;
        while (expected_verdicts.size() != 0)
            @(posedge clk);
        repeat (TABLE_DEPTH + 8) @(posedge clk);
        if (mismatch_count == 0)
            $display("access_policy_table verification clean");
        else
            $display("access_policy_table verification failed");
        $finish;
    end

endmodule

`default_nettype wire
